// ===== rtl/rbl_pkg.sv =====
// rbl_pkg: constants, codes and types shared by the rectangle block locator
// holds the request and response structs, the rectangle record and the query token
// no dependencies
package rbl_pkg;

    localparam int MAX_RECTS  = 64;
    localparam int COORD_BITS = 12;

    localparam int IDX_W     = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W     = IDX_W + 1;
    localparam int GUESS_W   = 6;
    localparam int INDEX_W   = 6;
    localparam int LEN_W     = COORD_BITS + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = COORD_BITS + 1;
    localparam int GC_W      = (CNT_W > GUESS_W) ? CNT_W : GUESS_W;

    localparam logic [LEN_W-1:0] LATTICE_MAX = {1'b1, {COORD_BITS{1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_LATTICE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LATTICE_HEIGHT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_LOCATE  = 2'd1,
        CMD_CHUNK_X = 2'd2,
        CMD_CHUNK_Y = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
        logic [GUESS_W-1:0]    start_guess;
    } req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] block_index;
        logic               hit;
        logic [LEN_W-1:0]   chunk_len;
        logic               fault;
    } rsp_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] bottom;
        logic [COORD_BITS-1:0] top;
    } rect_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [IDX_W-1:0]      guess;
        logic [CNT_W-1:0]      count;
        logic [IDX_W-1:0]      cur;
        logic                  hi_found;
        logic [IDX_W-1:0]      hi_idx;
        logic                  lo_found;
        logic [IDX_W-1:0]      lo_idx;
        logic [COORD_BITS-1:0] far;
        logic [LEN_W-1:0]      gap;
    } tok_t;

endpackage

// ===== rtl/rbl_cell.sv =====
// rbl_cell: one table entry of the locator chain
// holds one rectangle and updates the passing query token by one step
// depends on rbl_pkg
module rbl_cell
    import rbl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  rect_t wr_rect,
    input  logic  in_valid,
    input  tok_t  in_tok,
    output logic  out_valid,
    output tok_t  out_tok
);

    rect_t rect_reg;
    logic  out_valid_reg;
    tok_t  out_tok_reg;
    tok_t  tok_next;

    logic active;
    logic in_x;
    logic in_y;
    logic covered;
    logic past_guess;

    always_comb
    begin
        tok_next   = in_tok;
        active     = CNT_W'(in_tok.cur) < in_tok.count;
        in_x       = (in_tok.x >= rect_reg.left) && (in_tok.x <= rect_reg.right);
        in_y       = (in_tok.y >= rect_reg.bottom) && (in_tok.y <= rect_reg.top);
        covered    = active && in_x && in_y;
        past_guess = in_tok.cur >= in_tok.guess;

        if (covered && past_guess && !in_tok.hi_found)
        begin
            tok_next.hi_found = 1'b1;
            tok_next.hi_idx   = in_tok.cur;
            tok_next.far      = (in_tok.cmd == CMD_CHUNK_X) ? rect_reg.right : rect_reg.top;
        end
        if (covered && !past_guess && !in_tok.lo_found)
        begin
            tok_next.lo_found = 1'b1;
            tok_next.lo_idx   = in_tok.cur;
        end

        // nearest covered cell beyond the point along the chunk axis
        if (active && (in_tok.cmd == CMD_CHUNK_X) && in_y && (rect_reg.left > in_tok.x)
            && ({1'b0, rect_reg.left} < in_tok.gap))
        begin
            tok_next.gap = {1'b0, rect_reg.left};
        end
        if (active && (in_tok.cmd == CMD_CHUNK_Y) && in_x && (rect_reg.bottom > in_tok.y)
            && ({1'b0, rect_reg.bottom} < in_tok.gap))
        begin
            tok_next.gap = {1'b0, rect_reg.bottom};
        end

        tok_next.cur = in_tok.cur + IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rect_reg <= wr_rect;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            out_tok_reg <= tok_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;

endmodule

// ===== rtl/rect_block_locator_core.sv =====
// rect_block_locator_core: top level of the rectangle block locator
// holds the command decode, table count, lattice registers, response path and cell chain
// depends on rbl_pkg and rbl_cell
//
// An add command, or any request that faults, has its response staged in the pending
// register and moved to the output register from the drain state once that register is
// free; the next request is taken back in idle. A locate or chunk request sends a query
// token down a chain of MAX_RECTS cells, one cell per cycle, each cell holding one
// rectangle; the tail result is staged in the pending register and moved out the same
// way. One request is in flight at a time; a finished response waits in the output
// register while the next request is taken.
module rect_block_locator_core
    import rbl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp
);

    state_t state_reg;
    state_t state_next;

    logic [LEN_W-1:0] width_reg;
    logic [LEN_W-1:0] width_next;
    logic [LEN_W-1:0] height_reg;
    logic [LEN_W-1:0] height_next;
    logic [LEN_W-1:0] cfg_value;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    rsp_t pend_reg;
    rsp_t pend_next;
    rsp_t rsp_reg;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic load_out;

    logic             req_acc;
    logic             is_add;
    logic             add_fault;
    logic             qry_fault;
    logic             add_ok;
    logic             launch_valid;
    logic [GUESS_W-1:0] guess_sel;
    tok_t             launch_tok;
    rsp_t             imm_rsp;
    rsp_t             tail_rsp;
    rect_t            wr_rect;

    logic [MAX_RECTS-1:0] wr_en;
    logic [MAX_RECTS:0]   chain_valid;
    tok_t                 chain_tok [MAX_RECTS+1];
    tok_t                 tail_tok;
    logic [COORD_BITS-1:0] tail_along;

    // request decode
    assign req_acc   = req_valid && req_ready;
    assign is_add    = req.cmd == CMD_ADD;
    assign add_fault = ({1'b0, req.end_x} >= width_reg) || ({1'b0, req.end_y} >= height_reg)
                    || (req.pos_x > req.end_x) || (req.pos_y > req.end_y)
                    || (cnt_reg == CNT_W'(MAX_RECTS));
    assign guess_sel = (req.cmd == CMD_LOCATE) ? req.start_guess : '0;
    assign qry_fault = ({1'b0, req.pos_x} >= width_reg) || ({1'b0, req.pos_y} >= height_reg)
                    || (GC_W'(guess_sel) >= GC_W'(cnt_reg));
    assign add_ok       = req_acc && is_add && !add_fault;
    assign launch_valid = req_acc && !is_add && !qry_fault;

    assign wr_rect.left   = req.pos_x;
    assign wr_rect.right  = req.end_x;
    assign wr_rect.bottom = req.pos_y;
    assign wr_rect.top    = req.end_y;

    always_comb
    begin
        launch_tok          = '0;
        launch_tok.cmd      = req.cmd;
        launch_tok.x        = req.pos_x;
        launch_tok.y        = req.pos_y;
        launch_tok.guess    = IDX_W'(guess_sel);
        launch_tok.count    = cnt_reg;
        launch_tok.gap      = (req.cmd == CMD_CHUNK_Y) ? height_reg : width_reg;
    end

    always_comb
    begin
        imm_rsp       = '0;
        imm_rsp.fault = 1'b1;
        if (is_add && !add_fault)
        begin
            imm_rsp.block_index = INDEX_W'(cnt_reg);
            imm_rsp.fault       = 1'b0;
        end
    end

    // cell chain
    assign chain_valid[0] = launch_valid;
    assign chain_tok[0]   = launch_tok;

    for (genvar i = 0; i < MAX_RECTS; i++)
    begin : g_cell
        assign wr_en[i] = add_ok && (cnt_reg[IDX_W-1:0] == IDX_W'(i));

        rbl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_en     (wr_en[i]),
            .wr_rect   (wr_rect),
            .in_valid  (chain_valid[i]),
            .in_tok    (chain_tok[i]),
            .out_valid (chain_valid[i+1]),
            .out_tok   (chain_tok[i+1])
        );
    end

    assign tail_tok   = chain_tok[MAX_RECTS];
    assign tail_along = (tail_tok.cmd == CMD_CHUNK_Y) ? tail_tok.y : tail_tok.x;

    always_comb
    begin
        tail_rsp = '0;
        if (tail_tok.cmd == CMD_LOCATE)
        begin
            tail_rsp.hit = tail_tok.hi_found || tail_tok.lo_found;
            if (tail_tok.hi_found)
            begin
                tail_rsp.block_index = INDEX_W'(tail_tok.hi_idx);
            end
            else if (tail_tok.lo_found)
            begin
                tail_rsp.block_index = INDEX_W'(tail_tok.lo_idx);
            end
        end
        else
        begin
            tail_rsp.hit = tail_tok.hi_found;
            if (tail_tok.hi_found)
            begin
                tail_rsp.block_index = INDEX_W'(tail_tok.hi_idx);
                tail_rsp.chunk_len   = {1'b0, tail_tok.far} - {1'b0, tail_along} + LEN_W'(1);
            end
            else
            begin
                tail_rsp.chunk_len = tail_tok.gap - {1'b0, tail_along};
            end
        end
    end

    // state machine
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = launch_valid ? ST_SCAN : ST_DRAIN;
                end
            end
            ST_SCAN:
            begin
                if (chain_valid[MAX_RECTS])
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        load_out  = 1'b0;
        pend_next = pend_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_acc)
                begin
                    pend_next = imm_rsp;
                end
            end
            ST_SCAN:
            begin
                if (chain_valid[MAX_RECTS])
                begin
                    pend_next = tail_rsp;
                end
            end
            ST_DRAIN:
            begin
                load_out = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign rsp_valid_next = load_out || (rsp_valid_reg && !rsp_ready);
    assign cnt_next       = add_ok ? cnt_reg + CNT_W'(1) : cnt_reg;

    // lattice registers, saturated to the largest lattice
    assign cfg_value = (cfg_data > LATTICE_MAX) ? LATTICE_MAX : cfg_data;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LATTICE_WIDTH:  width_next  = cfg_value;
                CFG_LATTICE_HEIGHT: height_next = cfg_value;
                default:            width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            width_reg     <= LATTICE_MAX;
            height_reg    <= LATTICE_MAX;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (load_out)
        begin
            rsp_reg <= pend_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
        add_ok |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("table count did not advance on add");

    a_launch_scan: assert property (@(posedge clk) disable iff (!rst_n)
        launch_valid |=> (state_reg == ST_SCAN))
        else $error("query launched without entering scan");

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[MAX_RECTS] |-> (state_reg == ST_SCAN))
        else $error("query token left the chain outside scan");

    a_rsp_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> ($past(state_reg) == ST_DRAIN))
        else $error("response raised outside drain");

    a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.fault) |-> (!rsp.hit && (rsp.chunk_len == '0)
            && (rsp.block_index == '0)))
        else $error("faulted response carries data");
`endif

endmodule

// ===== tb/sv/rect_block_locator_core_test.sv =====
`timescale 1ns / 1ps
// rect_block_locator_core_test: self-checking bench for the rectangle block locator
// drives add, locate and chunk requests, predicts each response and checks it in order
// depends on rbl_pkg and rect_block_locator_core
module rect_block_locator_core_test;
    import rbl_pkg::*;

    localparam int TOTAL_ITEMS = 470;
    localparam int QUIET_TAIL  = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = MAX_RECTS + 4;

    class locate_checker;
        rect_t       rects[MAX_RECTS];
        int unsigned count;
        int unsigned lat_w;
        int unsigned lat_h;
        rsp_t        expected_rsps[$];
        int unsigned errors;

        function new();
            count  = 0;
            lat_w  = LATTICE_MAX;
            lat_h  = LATTICE_MAX;
            errors = 0;
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
            int unsigned v;
            v = (value > LATTICE_MAX) ? LATTICE_MAX : value;
            if (index == CFG_LATTICE_WIDTH)
                lat_w = v;
            else if (index == CFG_LATTICE_HEIGHT)
                lat_h = v;
        endfunction

        function bit covers(int unsigned i, int unsigned x, int unsigned y);
            return x >= rects[i].left && x <= rects[i].right &&
                   y >= rects[i].bottom && y <= rects[i].top;
        endfunction

        // scan upward from the guess, wrapping over the filled entries
        function bit find_block(int unsigned x, int unsigned y, int unsigned guess,
                                output int unsigned idx);
            int unsigned g;
            int unsigned n;
            g   = guess;
            idx = 0;
            for (n = 0; n < count; n++)
            begin
                if (covers(g, x, y))
                begin
                    idx = g;
                    return 1'b1;
                end
                g = (g + 1 >= count) ? 0 : g + 1;
            end
            return 1'b0;
        endfunction

        function rsp_t predict_response(req_t r);
            rsp_t        o;
            int unsigned x, y, ex, ey, guess, idx, i;
            int unsigned along, lo, hi, cand, nearest;
            bit          across_in;
            o  = '0;
            x  = r.pos_x;
            y  = r.pos_y;
            ex = r.end_x;
            ey = r.end_y;
            if (r.cmd == CMD_ADD)
            begin
                if (ex >= lat_w || ey >= lat_h || x > ex || y > ey || count >= MAX_RECTS)
                    o.fault = 1'b1;
                else
                begin
                    rects[count].left   = r.pos_x;
                    rects[count].right  = r.end_x;
                    rects[count].bottom = r.pos_y;
                    rects[count].top    = r.end_y;
                    o.block_index       = INDEX_W'(count);
                    count++;
                end
                return o;
            end
            guess = (r.cmd == CMD_LOCATE) ? r.start_guess : 0;
            if (x >= lat_w || y >= lat_h || guess >= count)
                o.fault = 1'b1;
            else if (find_block(x, y, guess, idx))
            begin
                o.hit         = 1'b1;
                o.block_index = INDEX_W'(idx);
                if (r.cmd == CMD_CHUNK_X)
                    o.chunk_len = LEN_W'(rects[idx].right - x + 1);
                else if (r.cmd == CMD_CHUNK_Y)
                    o.chunk_len = LEN_W'(rects[idx].top - y + 1);
            end
            else if (r.cmd != CMD_LOCATE)
            begin
                // gap up to the nearest covered cell along the axis, or the lattice edge
                along   = (r.cmd == CMD_CHUNK_X) ? x : y;
                nearest = (r.cmd == CMD_CHUNK_X) ? lat_w : lat_h;
                for (i = 0; i < count; i++)
                begin
                    if (r.cmd == CMD_CHUNK_X)
                    begin
                        lo        = rects[i].left;
                        hi        = rects[i].right;
                        across_in = y >= rects[i].bottom && y <= rects[i].top;
                    end
                    else
                    begin
                        lo        = rects[i].bottom;
                        hi        = rects[i].top;
                        across_in = x >= rects[i].left && x <= rects[i].right;
                    end
                    if (across_in && hi > along)
                    begin
                        cand = (lo > along) ? lo : along + 1;
                        if (cand < nearest)
                            nearest = cand;
                    end
                end
                o.chunk_len = LEN_W'(nearest - along);
            end
            return o;
        endfunction

        function void note_request(req_t r);
            expected_rsps.insert(expected_rsps.size(), predict_response(r));
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: response with none expected, expected nothing actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_rsps.pop_front();
            if (got.block_index !== want.block_index)
            begin
                $display("%0t: block_index expected %0d actual %0d",
                         $time, want.block_index, got.block_index);
                errors++;
            end
            if (got.hit !== want.hit)
            begin
                $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
                errors++;
            end
            if (got.chunk_len !== want.chunk_len)
            begin
                $display("%0t: chunk_len expected %0d actual %0d",
                         $time, want.chunk_len, got.chunk_len);
                errors++;
            end
            if (got.fault !== want.fault)
            begin
                $display("%0t: fault expected %0d actual %0d", $time, want.fault, got.fault);
                errors++;
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_LATTICE_WIDTH;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_t                 req       = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_t                 rsp;

    locate_checker sb = new();
    int unsigned   sent      = 0;
    bit            quiet     = 1'b0;
    bit            hold_ask  = 1'b0;
    bit            hold_done = 1'b0;

    rect_block_locator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic set_lattice(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LATTICE_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_LATTICE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.configure(CFG_LATTICE_WIDTH, w);
        sb.configure(CFG_LATTICE_HEIGHT, h);
    endtask

    task automatic send(input req_t r);
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(r);
        sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // stop offering, wait for every response, then let the block settle
    task automatic drain();
        if (req_valid)
            req_valid <= 1'b0;
        while (sb.expected_rsps.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic req_t mk(cmd_t c, int unsigned x, int unsigned y,
                                int unsigned ex, int unsigned ey, int unsigned g);
        req_t r;
        r.cmd         = c;
        r.pos_x       = COORD_BITS'(x);
        r.pos_y       = COORD_BITS'(y);
        r.end_x       = COORD_BITS'(ex);
        r.end_y       = COORD_BITS'(ey);
        r.start_guess = GUESS_W'(g);
        return r;
    endfunction

    function automatic int unsigned pick_span(int unsigned room);
        int unsigned cap, sel;
        sel = $urandom_range(0, 19);
        cap = (sel < 14) ? 31 : (sel < 19) ? 511 : 4095;
        return $urandom_range(0, (room < cap) ? room : cap);
    endfunction

    function automatic req_t make_request();
        req_t        r;
        rect_t       b;
        int unsigned w, h, pick, sel;
        w = sb.lat_w;
        h = sb.lat_h;
        r = mk(CMD_ADD, $urandom_range(0, 4095), $urandom_range(0, 4095),
               $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 63));
        sel = $urandom_range(0, 99);
        if (sel < 25)
            r.cmd = CMD_ADD;
        else if (sel < 55)
            r.cmd = CMD_LOCATE;
        else if (sel < 78)
            r.cmd = CMD_CHUNK_X;
        else
            r.cmd = CMD_CHUNK_Y;
        pick = $urandom_range(0, 99);
        if (r.cmd == CMD_ADD)
        begin
            if (pick < 70 && w > 0 && h > 0)
            begin
                r.pos_x = COORD_BITS'($urandom_range(0, w - 1));
                r.end_x = COORD_BITS'(r.pos_x + pick_span(w - 1 - r.pos_x));
                r.pos_y = COORD_BITS'($urandom_range(0, h - 1));
                r.end_y = COORD_BITS'(r.pos_y + pick_span(h - 1 - r.pos_y));
            end
            else if (pick < 78)
            begin
                r.end_x = COORD_BITS'($urandom_range(0, 4094));
                r.pos_x = COORD_BITS'($urandom_range(r.end_x + 1, 4095));
            end
            else if (pick < 86)
            begin
                r.end_y = COORD_BITS'($urandom_range(0, 4094));
                r.pos_y = COORD_BITS'($urandom_range(r.end_y + 1, 4095));
            end
            return r;
        end
        if (pick < 60 && sb.count > 0)
        begin
            b = sb.rects[$urandom_range(0, sb.count - 1)];
            r.pos_x = COORD_BITS'($urandom_range(b.left, b.right));
            r.pos_y = COORD_BITS'($urandom_range(b.bottom, b.top));
            // just past the far edge
            if (pick < 8)
                r.pos_x = COORD_BITS'(b.right + 1);
            else if (pick < 16)
                r.pos_y = COORD_BITS'(b.top + 1);
        end
        else if (pick < 88 && w > 0 && h > 0)
        begin
            r.pos_x = COORD_BITS'($urandom_range(0, w - 1));
            r.pos_y = COORD_BITS'($urandom_range(0, h - 1));
        end
        if (sb.count > 0 && $urandom_range(0, 9) != 0)
            r.start_guess = GUESS_W'($urandom_range(0, sb.count - 1));
        return r;
    endfunction

    // receiver with short random stalls and one long hold-off
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp);
            if (hold_ask)
            begin
                hold_ask   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 4);
            if (stall_left > 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    initial
    begin
        int unsigned still;
        still = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                still = 0;
            else
            begin
                still++;
                if (still >= STALL_LIMIT)
                begin
                    $display("rect_block_locator_core test failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int unsigned w, h, n, k, phase, sel;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, corner rectangles, inverted adds, hits, misses, guess faults
        send(mk(CMD_LOCATE, 0, 0, 0, 0, 0));
        send(mk(CMD_CHUNK_X, 0, 0, 0, 0, 0));
        send(mk(CMD_CHUNK_Y, 5, 5, 0, 0, 0));
        send(mk(CMD_ADD, 0, 0, 0, 0, 0));
        send(mk(CMD_ADD, 4095, 4095, 4095, 4095, 63));
        send(mk(CMD_ADD, 100, 200, 299, 399, 0));
        send(mk(CMD_ADD, 500, 10, 499, 20, 0));
        send(mk(CMD_ADD, 10, 500, 20, 499, 0));
        send(mk(CMD_LOCATE, 0, 0, 0, 0, 0));
        send(mk(CMD_LOCATE, 4095, 4095, 0, 0, 1));
        send(mk(CMD_LOCATE, 150, 250, 0, 0, 2));
        send(mk(CMD_LOCATE, 150, 250, 0, 0, 0));
        send(mk(CMD_LOCATE, 150, 250, 0, 0, 3));
        send(mk(CMD_LOCATE, 150, 250, 0, 0, 63));
        send(mk(CMD_LOCATE, 1000, 1000, 0, 0, 1));
        send(mk(CMD_CHUNK_X, 100, 200, 0, 0, 0));
        send(mk(CMD_CHUNK_Y, 150, 399, 0, 0, 0));
        send(mk(CMD_CHUNK_X, 0, 4095, 0, 0, 0));
        send(mk(CMD_CHUNK_X, 4094, 0, 0, 0, 0));
        send(mk(CMD_CHUNK_Y, 0, 1, 0, 0, 0));
        send(mk(CMD_CHUNK_Y, 4095, 0, 0, 0, 0));
        send(mk(CMD_CHUNK_X, 0, 1, 4095, 4095, 63));
        drain();

        phase = 0;
        while (sent < TOTAL_ITEMS)
        begin
            case (phase)
                0: begin w = 8191; h = 4097; end
                1: begin w = 1; h = 1; end
                2: begin w = 0; h = 4096; end
                3: begin w = 4096; h = 0; end
                4: begin w = 16; h = 16; end
                5: begin w = 4096; h = 4096; end
                default:
                begin
                    sel = $urandom_range(0, 5);
                    case (sel)
                        1: begin w = $urandom_range(1, 4096); h = $urandom_range(1, 4096); end
                        2: begin w = $urandom_range(2, 64); h = $urandom_range(2, 64); end
                        3: begin w = $urandom_range(4097, 8191); h = $urandom_range(1, 4096); end
                        4: begin w = 1; h = $urandom_range(1, 4096); end
                        default: begin w = 4096; h = 4096; end
                    endcase
                end
            endcase
            set_lattice(CFG_W'(w), CFG_W'(h));
            n = (w == 0 || h == 0) ? 8 : 30;
            for (k = 0; k < n && sent < TOTAL_ITEMS; k++)
            begin
                quiet = (sent >= TOTAL_ITEMS - QUIET_TAIL);
                if (!hold_done && sent >= 200 && k == 3)
                begin
                    hold_ask  = 1'b1;
                    hold_done = 1'b1;
                end
                send(make_request());
            end
            drain();
            phase++;
        end

        if (sb.errors == 0 && sb.expected_rsps.size() == 0)
            $display("rect_block_locator_core test passed");
        else
            $display("rect_block_locator_core test failed");
        $finish;
    end

endmodule
